@@ rtl/core/angle_approach_step_limited_core_assert.svh @@
// Assertion macros for the angle approach core.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ANGLE_APPROACH_STEP_LIMITED_CORE_ASSERT_SVH
`define ANGLE_APPROACH_STEP_LIMITED_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define AASL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aasl assertion failed");

`define AASL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aasl assertion failed");

`else

`define AASL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AASL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/aasl_pkg.sv @@
// Shared types and constants of the angle approach core.
// No dependencies.
`default_nettype none

package aasl_pkg;

   localparam int unsigned ValueWidth = 16;
   localparam int unsigned FracWidth  = 17;
   localparam int unsigned StepWidth  = 15;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = FracWidth;

   typedef logic [ValueWidth-1:0]   value_type;
   typedef logic [FracWidth-1:0]    frac_type;
   typedef logic [StepWidth-1:0]    step_type;
   typedef logic [CsrIdxWidth-1:0]  csr_idx_type;
   typedef logic [CsrDataWidth-1:0] csr_data_type;

   localparam csr_idx_type CSR_APPROACH_FRACTION = 2'd0;
   localparam csr_idx_type CSR_MAX_STEP          = 2'd1;
   localparam csr_idx_type CSR_MIN_STEP          = 2'd2;

   localparam frac_type RESET_FRACTION = 17'd32768;
   localparam step_type RESET_MAX_STEP = 15'd1024;
   localparam step_type RESET_MIN_STEP = 15'd16;

endpackage

`default_nettype wire

@@ rtl/core/angle_approach_step_limited_core.sv @@
// Angle approach core: rate-limited exponential approach of a signed 16-bit value.
// Uses aasl_pkg and angle_approach_step_limited_core_assert.svh.
//
// Usage:
//   req_ channel carries one target per item; rsp_ channel returns the new held
//   value and the wrapped remaining difference, one result item per request item.
//   csr_ channel writes approach_fraction (0), max_step (1), min_step (2); other
//   indexes are dropped. csr_ready is always high; write only while idle.
// Flow: an accepted item is captured in the input register, computed and
//   loaded into the result register once the result register is free; the
//   result register drives the rsp_ channel.
// Throughput: one item per cycle while rsp_ready stays high. The held-value
//   feedback (one 17x17 multiply, clamp, add and snap compare) is combinational.
// Reset: held value clears to zero, CSR registers take their reset values, both
//   pipeline stages empty.
// Stall: while rsp_ready is low the result holds; one more item can wait in
//   the input register, after which req_ready drops.
`default_nettype none

`include "angle_approach_step_limited_core_assert.svh"

module angle_approach_step_limited_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic signed [15:0]           req_target_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic signed [15:0]           rsp_new_value,
   output      logic signed [15:0]           rsp_remaining_diff,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire aasl_pkg::csr_idx_type        csr_index,
   input  wire aasl_pkg::csr_data_type       csr_data
);

   aasl_pkg::frac_type  frac_ff;
   aasl_pkg::step_type  max_step_ff;
   aasl_pkg::step_type  min_step_ff;
   aasl_pkg::value_type held_ff, held_in;

   logic                in_valid_ff;
   aasl_pkg::value_type in_target_ff;
   logic                out_valid_ff;
   aasl_pkg::value_type out_new_ff, out_rem_ff, out_rem_in;

   logic                advance;
   logic                stall_full;

   logic [15:0] diff, moved, rem_moved;
   logic        neg, big, up, snap;
   logic [16:0] diff_ext, mag;
   logic [33:0] product;
   logic [17:0] smag;
   logic [14:0] clamp, step_mag;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff     <= aasl_pkg::RESET_FRACTION;
         max_step_ff <= aasl_pkg::RESET_MAX_STEP;
         min_step_ff <= aasl_pkg::RESET_MIN_STEP;
      end else if (csr_valid) begin
         unique case (csr_index)
            aasl_pkg::CSR_APPROACH_FRACTION: frac_ff <= csr_data;
            aasl_pkg::CSR_MAX_STEP:          max_step_ff <= csr_data[14:0];
            aasl_pkg::CSR_MIN_STEP:          min_step_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Handshake: result register frees when empty or taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign stall_full = out_valid_ff && !rsp_ready && in_valid_ff;

   // Step computation
   always_comb begin
      diff     = in_target_ff - held_ff;
      neg      = diff[15];
      diff_ext = {diff[15], diff};
      mag      = neg ? (~diff_ext + 17'd1) : diff_ext;
      product  = {17'd0, mag} * {17'd0, frac_ff};
      smag     = product[33:16];
      big      = smag > {3'd0, min_step_ff};
      clamp    = (smag > {3'd0, max_step_ff}) ? max_step_ff : smag[14:0];
      step_mag = big ? clamp : min_step_ff;
      if (neg) begin
         up = 1'b0;
      end else if (big) begin
         up = step_mag != 15'd0;
      end else begin
         up = 1'b1;
      end
      moved     = up ? (held_ff + {1'b0, step_mag}) : (held_ff - {1'b0, step_mag});
      rem_moved = in_target_ff - moved;
      snap      = up ? rem_moved[15] : (rem_moved != 16'd0 && !rem_moved[15]);
      if (in_target_ff == held_ff) begin
         held_in = held_ff;
      end else if (snap) begin
         held_in = in_target_ff;
      end else begin
         held_in = moved;
      end
      out_rem_in = in_target_ff - held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            held_ff      <= held_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_target_ff <= req_target_value;
      end
      if (advance) begin
         out_new_ff <= held_in;
         out_rem_ff <= out_rem_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_new_value      = out_new_ff;
   assign rsp_remaining_diff = out_rem_ff;

   `AASL_ASSERT_IMPL(a_full_stall_blocks, clock, reset, stall_full, !req_ready)
   `AASL_ASSERT_NEXT(a_held_matches_result, clock, reset, advance, held_ff == out_new_ff)
   `AASL_ASSERT_NEXT(a_held_only_on_advance, clock, reset, !advance, $stable(held_ff))

endmodule

`default_nettype wire
